// ===== rtl/core/smi_pkg.sv =====
// Shared widths, size codes, item types and cofactor index tables for the matrix inverse core.
package smi_pkg;

  localparam int WW = 32;              // entry word width
  localparam int FB = 16;              // fraction bits
  localparam int NE = 9;               // entries of a 3x3 matrix
  localparam int PW = 2 * WW;          // product / cofactor width
  localparam int DW = 3 * WW + 1;      // determinant width
  localparam int NW = PW + 2 * FB + 2; // scaled dividend width
  localparam int QW = WW;              // quotient bits developed
  localparam int RW = DW + QW + 1;     // partial remainder width

  localparam int ADJ_STAGES = 2;
  localparam int DET_STAGES = 3;
  localparam int DIV_STAGES = QW + 3;
  localparam int FMT_STAGES = 1;
  localparam int DEPTH = ADJ_STAGES + DET_STAGES + DIV_STAGES + FMT_STAGES;

  localparam logic [1:0] SIZE_NONE = 2'd0;
  localparam logic [1:0] SIZE_1    = 2'd1;
  localparam logic [1:0] SIZE_2    = 2'd2;
  localparam logic [1:0] SIZE_3    = 2'd3;

  // cofactor k = a[XI]*a[YI] - a[UI]*a[VI], row-major indexes
  localparam int XI [NE] = '{4, 7, 1, 5, 8, 2, 3, 6, 0};
  localparam int YI [NE] = '{8, 2, 5, 6, 0, 3, 7, 1, 4};
  localparam int UI [NE] = '{5, 8, 2, 3, 6, 0, 4, 7, 1};
  localparam int VI [NE] = '{7, 1, 4, 8, 2, 5, 6, 0, 3};

  typedef logic signed [WW-1:0] word_t;
  typedef logic signed [PW-1:0] cof_t;
  typedef logic signed [DW-1:0] det_t;

  typedef struct packed {
    logic [1:0] size;
    word_t a11;
    word_t a12;
    word_t a13;
    word_t a21;
    word_t a22;
    word_t a23;
    word_t a31;
    word_t a32;
    word_t a33;
  } in_item_t;

  typedef struct packed {
    word_t b11;
    word_t b12;
    word_t b13;
    word_t b21;
    word_t b22;
    word_t b23;
    word_t b31;
    word_t b32;
    word_t b33;
    logic  singular;
    logic  saturated;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        size;
    logic [NE-1:0]     have;
    cof_t [NE-1:0]     num;
    word_t [2:0]       row1;
    cof_t              det_short;
  } adj_t;

  typedef struct packed {
    logic [1:0]    size;
    logic [NE-1:0] have;
    cof_t [NE-1:0] num;
    det_t          det;
  } detd_t;

  typedef struct packed {
    logic [1:0]              size;
    logic [NE-1:0]           have;
    logic [NE-1:0]           neg;
    logic [NE-1:0]           sat;
    logic                    dz;
    logic [DW-1:0]           d2;
    logic [NE-1:0][RW-1:0]   rem;
    logic [NE-1:0][QW-1:0]   quo;
  } quo_t;

endpackage

// ===== rtl/core/smi_adjugate.sv =====
// Products, cofactors and per-size numerator selection (two stages).
module smi_adjugate import smi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_ready,
  input  in_item_t up_item,
  output logic     dn_valid,
  input  logic     dn_ready,
  output adj_t     dn_item
);

  word_t a [NE];
  logic v1, go1, go2;
  cof_t pa [NE];
  cof_t pb [NE];
  logic [1:0] size1;
  word_t k11, k12, k13, k21, k22;
  cof_t cof [NE];
  adj_t nxt;

  assign a[0] = up_item.a11;
  assign a[1] = up_item.a12;
  assign a[2] = up_item.a13;
  assign a[3] = up_item.a21;
  assign a[4] = up_item.a22;
  assign a[5] = up_item.a23;
  assign a[6] = up_item.a31;
  assign a[7] = up_item.a32;
  assign a[8] = up_item.a33;

  assign go2 = !dn_valid || dn_ready;
  assign go1 = !v1 || go2;
  assign up_ready = go1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (go1) v1 <= up_valid;
      if (go2) dn_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (go1) begin
      for (int k = 0; k < NE; k++) begin
        pa[k] <= a[XI[k]] * a[YI[k]];
        pb[k] <= a[UI[k]] * a[VI[k]];
      end
      size1 <= up_item.size;
      k11 <= a[0];
      k12 <= a[1];
      k13 <= a[2];
      k21 <= a[3];
      k22 <= a[4];
    end
  end

  always_comb begin
    for (int k = 0; k < NE; k++) cof[k] = pa[k] - pb[k];
    nxt = '0;
    nxt.size = size1;
    nxt.row1[0] = k11;
    nxt.row1[1] = k12;
    nxt.row1[2] = k13;
    case (size1)
      SIZE_1: begin
        nxt.have = NE'(1);
        nxt.num[0] = cof_t'(1);
        nxt.det_short = cof_t'(k11);
      end
      SIZE_2: begin
        nxt.have = NE'(9'b000011011);
        nxt.num[0] = cof_t'(k22);
        nxt.num[1] = -cof_t'(k12);
        nxt.num[3] = -cof_t'(k21);
        nxt.num[4] = cof_t'(k11);
        nxt.det_short = cof[8];
      end
      SIZE_3: begin
        nxt.have = '1;
        for (int k = 0; k < NE; k++) nxt.num[k] = cof[k];
        nxt.det_short = cof[8];
      end
      default: begin
        nxt.have = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (go2) dn_item <= nxt;
  end

endmodule

// ===== rtl/core/smi_determinant.sv =====
// Determinant by first-row expansion: split products, recombine, sum (three stages).
module smi_determinant import smi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  adj_t  up_item,
  output logic  dn_valid,
  input  logic  dn_ready,
  output detd_t dn_item
);

  logic v1, v2, go1, go2, go3;
  adj_t s1, s2;
  logic signed [2*WW:0] lo [3];
  cof_t hi [3];
  det_t t [3];
  detd_t nxt;

  assign go3 = !dn_valid || dn_ready;
  assign go2 = !v2 || go3;
  assign go1 = !v1 || go2;
  assign up_ready = go1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      dn_valid <= 1'b0;
    end else begin
      if (go1) v1 <= up_valid;
      if (go2) v2 <= v1;
      if (go3) dn_valid <= v2;
    end
  end

  // a1k times cofactor, cofactor split into low unsigned and high signed halves
  always_ff @(posedge clk) begin
    if (go1) begin
      s1 <= up_item;
      for (int k = 0; k < 3; k++) begin
        lo[k] <= up_item.row1[k] * $signed({1'b0, up_item.num[3*k][WW-1:0]});
        hi[k] <= up_item.row1[k] * $signed(up_item.num[3*k][PW-1:WW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go2) begin
      s2 <= s1;
      for (int k = 0; k < 3; k++) t[k] <= (det_t'(hi[k]) <<< WW) + det_t'(lo[k]);
    end
  end

  always_comb begin
    nxt.size = s2.size;
    nxt.have = s2.have;
    nxt.num = s2.num;
    if (s2.size == SIZE_3) nxt.det = t[0] + t[1] + t[2];
    else nxt.det = det_t'($signed(s2.det_short));
  end

  always_ff @(posedge clk) begin
    if (go3) dn_item <= nxt;
  end

endmodule

// ===== rtl/core/smi_divider.sv =====
// Nine restoring dividers, one quotient bit per stage, with sign and range prep.
module smi_divider import smi_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  up_valid,
  output logic  up_ready,
  input  detd_t up_item,
  output logic  dn_valid,
  input  logic  dn_ready,
  output quo_t  dn_item
);

  localparam int NS = QW + 3;

  typedef struct packed {
    logic [1:0]            size;
    logic [NE-1:0]         have;
    logic [NE-1:0]         neg;
    logic [NE-1:0][PW-1:0] nmag;
    logic [DW-1:0]         dmag;
    logic                  dz;
  } mag_t;

  typedef struct packed {
    logic [1:0]            size;
    logic [NE-1:0]         have;
    logic [NE-1:0]         neg;
    logic                  dz;
    logic [DW-1:0]         d2;
    logic [NE-1:0][NW-1:0] nn;
    logic [NE-1:0][RW-1:0] thr;
  } scl_t;

  logic [NS-1:0] v;
  logic [NS:0] go;
  mag_t m1;
  scl_t s2;
  quo_t it [QW+1];

  function automatic quo_t div_step(quo_t s, int b);
    quo_t r;
    logic [RW-1:0] sh;
    r = s;
    sh = RW'(s.d2) << b;
    for (int k = 0; k < NE; k++) begin
      if (s.rem[k] >= sh) begin
        r.rem[k] = s.rem[k] - sh;
        r.quo[k][b] = 1'b1;
      end
    end
    return r;
  endfunction

  assign go[NS] = dn_ready;
  for (genvar g = 0; g < NS; g++) begin : g_go
    assign go[g] = !v[g] || go[g+1];
  end
  assign up_ready = go[0];
  assign dn_valid = v[NS-1];
  assign dn_item = it[QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) v[0] <= up_valid;
      for (int g = 1; g < NS; g++) begin
        if (go[g]) v[g] <= v[g-1];
      end
    end
  end

  // signs and magnitudes
  always_ff @(posedge clk) begin
    if (go[0]) begin
      m1.size <= up_item.size;
      m1.have <= up_item.have;
      m1.dz <= (up_item.det == '0);
      m1.dmag <= up_item.det[DW-1] ? DW'(-up_item.det) : DW'(up_item.det);
      for (int k = 0; k < NE; k++) begin
        m1.neg[k] <= up_item.num[k][PW-1] ^ up_item.det[DW-1];
        m1.nmag[k] <= up_item.num[k][PW-1] ? PW'(-up_item.num[k]) : PW'(up_item.num[k]);
      end
    end
  end

  // rounded dividend 2|N|*2^2F + |D|, divisor 2|D|, saturation threshold
  always_ff @(posedge clk) begin
    if (go[1]) begin
      s2.size <= m1.size;
      s2.have <= m1.have;
      s2.neg <= m1.neg;
      s2.dz <= m1.dz;
      s2.d2 <= {m1.dmag[DW-2:0], 1'b0};
      for (int k = 0; k < NE; k++) begin
        s2.nn[k] <= (NW'(m1.nmag[k]) << (2 * FB + 1)) + NW'(m1.dmag);
        s2.thr[k] <= (RW'({m1.dmag[DW-2:0], 1'b0}) << (QW - 1))
                     + (m1.neg[k] ? RW'({m1.dmag[DW-2:0], 1'b0}) : RW'(0));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[2]) begin
      it[0].size <= s2.size;
      it[0].have <= s2.have;
      it[0].neg <= s2.neg;
      it[0].dz <= s2.dz;
      it[0].d2 <= s2.d2;
      it[0].quo <= '0;
      for (int k = 0; k < NE; k++) begin
        it[0].sat[k] <= (RW'(s2.nn[k]) >= s2.thr[k]);
        it[0].rem[k] <= RW'(s2.nn[k]);
      end
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_iter
    always_ff @(posedge clk) begin
      if (go[j+2]) it[j] <= div_step(it[j-1], QW - j);
    end
  end

endmodule

// ===== rtl/core/small_matrix_inverse_core.sv =====
// Top level: closed-form 1x1/2x2/3x3 fixed-point matrix inverse pipeline.
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------
//   mat     | mat_valid/mat_stall | in_item_t: size, a11..a33 (Q16.16)
//   inv     | inv_valid/inv_stall | out_item_t: b11..b33, singular, saturated
//
// One item enters per cycle while no stall on inv holds the pipe; DEPTH
// counts two cofactor stages, three determinant stages, three divider
// prep stages, one stage per quotient bit (32), and the output register.
// The per-bit restoring divide sets the depth. rst clears all valid bits;
// payload is not reset. A stall on inv only blocks stages that hold an
// item, so bubbles collapse and mat keeps accepting until the pipe is full.
module small_matrix_inverse_core import smi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      mat_valid,
  output logic      mat_stall,
  input  in_item_t  mat,
  output logic      inv_valid,
  input  logic      inv_stall,
  output out_item_t inv
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [QW-1:0] TOP_MAG = QW'(1) << (QW - 1);

  logic  adj_valid, adj_ready, det_valid, det_ready, quo_valid, quo_ready;
  logic  mat_ready;
  adj_t  adj;
  detd_t detd;
  quo_t  quo;
  word_t b [NE];
  logic  sat_any;
  logic  fmt_go;
  logic [CW-1:0] inflight;

  assign mat_stall = !mat_ready;

  smi_adjugate u_adj (
    .clk      (clk),
    .rst      (rst),
    .up_valid (mat_valid),
    .up_ready (mat_ready),
    .up_item  (mat),
    .dn_valid (adj_valid),
    .dn_ready (adj_ready),
    .dn_item  (adj)
  );

  smi_determinant u_det (
    .clk      (clk),
    .rst      (rst),
    .up_valid (adj_valid),
    .up_ready (adj_ready),
    .up_item  (adj),
    .dn_valid (det_valid),
    .dn_ready (det_ready),
    .dn_item  (detd)
  );

  smi_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (det_valid),
    .up_ready (det_ready),
    .up_item  (detd),
    .dn_valid (quo_valid),
    .dn_ready (quo_ready),
    .dn_item  (quo)
  );

  // Output stage: clamp, apply sign, zero unused or singular entries.
  always_comb begin
    logic [QW-1:0] qv;
    sat_any = 1'b0;
    for (int k = 0; k < NE; k++) begin
      if (quo.sat[k]) qv = quo.neg[k] ? TOP_MAG : TOP_MAG - 1'b1;
      else qv = quo.quo[k];
      if (quo.have[k] && !quo.dz) b[k] = quo.neg[k] ? -WW'(qv) : WW'(qv);
      else b[k] = '0;
      if (quo.have[k] && quo.sat[k]) sat_any = 1'b1;
    end
  end

  assign fmt_go = !inv_valid || !inv_stall;
  assign quo_ready = fmt_go;

  always_ff @(posedge clk) begin
    if (rst) inv_valid <= 1'b0;
    else if (fmt_go) inv_valid <= quo_valid;
  end

  always_ff @(posedge clk) begin
    if (fmt_go) begin
      inv.b11 <= b[0];
      inv.b12 <= b[1];
      inv.b13 <= b[2];
      inv.b21 <= b[3];
      inv.b22 <= b[4];
      inv.b23 <= b[5];
      inv.b31 <= b[6];
      inv.b32 <= b[7];
      inv.b33 <= b[8];
      inv.singular <= quo.dz && (quo.size != SIZE_NONE);
      inv.saturated <= sat_any && !quo.dz;
    end
  end

  // items between the two handshakes, for the checks below
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      case ({mat_valid && mat_ready, inv_valid && !inv_stall})
        2'b10:   inflight <= inflight + 1'b1;
        2'b01:   inflight <= inflight - 1'b1;
        default: inflight <= inflight;
      endcase
    end
  end

  a_sing_no_sat: assert property (@(posedge clk) disable iff (rst)
    inv_valid && inv.singular |-> !inv.saturated)
    else $error("singular result flagged saturated");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    inv_valid && inv.singular |-> inv.b11 == '0 && inv.b12 == '0 && inv.b13 == '0 &&
      inv.b21 == '0 && inv.b22 == '0 && inv.b23 == '0 &&
      inv.b31 == '0 && inv.b32 == '0 && inv.b33 == '0)
    else $error("singular result has nonzero entries");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    inv_valid |-> inflight != '0)
    else $error("result shown with no item in flight");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= CW'(DEPTH))
    else $error("more items in flight than pipeline stages");

endmodule
